// ----- sv/pld_pkg.sv -----
// shared widths and control type for the point-to-line distance pipeline
`timescale 1ns / 1ps

package pld_pkg;

    // input coordinate width, signed q16.16
    localparam int CW      = 32;
    // base minus point, one bit wider
    localparam int DW      = CW + 1;
    // one cross product term, signed
    localparam int PW      = DW + CW;
    // cross product component, signed, and its magnitude
    localparam int MW      = PW + 1;
    localparam int MAG_W   = MW - 1;
    // low half width used to split the magnitude for squaring
    localparam int LO_W    = 32;
    localparam int HI_W    = MAG_W - LO_W;
    // squared length of the cross product and of the direction
    localparam int MSQ_W   = 2 * MAG_W;
    localparam int VSQ_W   = 2 * CW;
    // quotient bits: the quotient is bounded by |b - p|^2
    localparam int QW      = MSQ_W - VSQ_W;
    // integer square root of the quotient
    localparam int RT_W    = QW / 2;
    localparam int SRM_W   = RT_W + 2;
    localparam int DIST_W  = 34;

    // stage count of the front section
    localparam int FRONT_STAGES = 7;

    // control that travels with every beat
    typedef struct packed {
        logic valid;
        logic on_line;
        logic degen;
    } pld_ctl_t;

endpackage

// ----- sv/pld_in_if.sv -----
// input channel: point, line base and line direction
`timescale 1ns / 1ps

interface pld_in_if;
    import pld_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic signed [CW-1:0] base_x;
    logic signed [CW-1:0] base_y;
    logic signed [CW-1:0] base_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;

    modport source (
        output valid, point_x, point_y, point_z, base_x, base_y, base_z,
               dir_x, dir_y, dir_z,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z, base_x, base_y, base_z,
               dir_x, dir_y, dir_z,
        output ready
    );
endinterface

// ----- sv/pld_out_if.sv -----
// output channel: flags and distance
`timescale 1ns / 1ps

interface pld_out_if;
    import pld_pkg::*;

    logic              valid;
    logic              ready;
    logic              on_line;
    logic              degenerate;
    logic [DIST_W-1:0] distance;

    modport source (
        output valid, on_line, degenerate, distance,
        input  ready
    );

    modport sink (
        input  valid, on_line, degenerate, distance,
        output ready
    );
endinterface

// ----- sv/pld_front.sv -----
// front pipeline: cross product, flags and squared lengths
`timescale 1ns / 1ps

module pld_front
    import pld_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] point_x,
    input  logic signed [CW-1:0] point_y,
    input  logic signed [CW-1:0] point_z,
    input  logic signed [CW-1:0] base_x,
    input  logic signed [CW-1:0] base_y,
    input  logic signed [CW-1:0] base_z,
    input  logic signed [CW-1:0] dir_x,
    input  logic signed [CW-1:0] dir_y,
    input  logic signed [CW-1:0] dir_z,
    output pld_ctl_t             ctl,
    output logic [MSQ_W-1:0]     msq,
    output logic [VSQ_W-1:0]     vsq
);

    // valid bits of the seven stages
    logic [FRONT_STAGES:1] vld_reg;
    logic [FRONT_STAGES:1] degen_reg;

    // stage 1 registers
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [CW-1:0] vx_reg, vy_reg, vz_reg;
    // stage 2 registers
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    logic [VSQ_W-1:0]     sx_reg, sy_reg, sz_reg;
    // stage 3 registers
    logic signed [MW-1:0] mx_reg, my_reg, mz_reg;
    logic [VSQ_W-1:0]     vsq3_reg;
    // stage 4 registers
    logic [MAG_W-1:0]     ax_reg, ay_reg, az_reg;
    logic                 on4_reg;
    logic [VSQ_W-1:0]     vsq4_reg;
    // stage 5 registers
    logic [2*LO_W-1:0]        llx_reg, lly_reg, llz_reg;
    logic [HI_W+LO_W-1:0]     hlx_reg, hly_reg, hlz_reg;
    logic [2*HI_W-1:0]        hhx_reg, hhy_reg, hhz_reg;
    logic                     on5_reg;
    logic [VSQ_W-1:0]         vsq5_reg;
    // stage 6 registers
    logic [MSQ_W-1:0]     qx_reg, qy_reg, qz_reg;
    logic                 on6_reg;
    logic [VSQ_W-1:0]     vsq6_reg;
    // stage 7 registers
    logic [MSQ_W-1:0]     msq_reg;
    logic                 on7_reg;
    logic [VSQ_W-1:0]     vsq7_reg;

    // valid and degenerate flag travel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-1:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            degen_reg <= {degen_reg[FRONT_STAGES-1:1],
                          (dir_x == '0) && (dir_y == '0) && (dir_z == '0)};
        end
    end

    // stage 1: base minus point
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= DW'(base_x) - DW'(point_x);
            dy_reg <= DW'(base_y) - DW'(point_y);
            dz_reg <= DW'(base_z) - DW'(point_z);
            vx_reg <= dir_x;
            vy_reg <= dir_y;
            vz_reg <= dir_z;
        end
    end

    // stage 2: cross product terms and direction squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= PW'(dy_reg) * PW'(vz_reg);
            pb_reg <= PW'(dz_reg) * PW'(vy_reg);
            pc_reg <= PW'(dz_reg) * PW'(vx_reg);
            pd_reg <= PW'(dx_reg) * PW'(vz_reg);
            pe_reg <= PW'(dx_reg) * PW'(vy_reg);
            pf_reg <= PW'(dy_reg) * PW'(vx_reg);
            sx_reg <= VSQ_W'(VSQ_W'(vx_reg) * VSQ_W'(vx_reg));
            sy_reg <= VSQ_W'(VSQ_W'(vy_reg) * VSQ_W'(vy_reg));
            sz_reg <= VSQ_W'(VSQ_W'(vz_reg) * VSQ_W'(vz_reg));
        end
    end

    // stage 3: cross product components and direction length
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg   <= MW'(pa_reg) - MW'(pb_reg);
            my_reg   <= MW'(pc_reg) - MW'(pd_reg);
            mz_reg   <= MW'(pe_reg) - MW'(pf_reg);
            vsq3_reg <= sx_reg + sy_reg + sz_reg;
        end
    end

    // stage 4: magnitudes and zero test
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg   <= mx_reg[MW-1] ? MAG_W'(-mx_reg) : MAG_W'(mx_reg);
            ay_reg   <= my_reg[MW-1] ? MAG_W'(-my_reg) : MAG_W'(my_reg);
            az_reg   <= mz_reg[MW-1] ? MAG_W'(-mz_reg) : MAG_W'(mz_reg);
            on4_reg  <= (mx_reg == '0) && (my_reg == '0) && (mz_reg == '0);
            vsq4_reg <= vsq3_reg;
        end
    end

    // stage 5: partial products of each square
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            llx_reg  <= (2*LO_W)'(ax_reg[LO_W-1:0]) * (2*LO_W)'(ax_reg[LO_W-1:0]);
            lly_reg  <= (2*LO_W)'(ay_reg[LO_W-1:0]) * (2*LO_W)'(ay_reg[LO_W-1:0]);
            llz_reg  <= (2*LO_W)'(az_reg[LO_W-1:0]) * (2*LO_W)'(az_reg[LO_W-1:0]);
            hlx_reg  <= (HI_W+LO_W)'(ax_reg[MAG_W-1:LO_W])
                        * (HI_W+LO_W)'(ax_reg[LO_W-1:0]);
            hly_reg  <= (HI_W+LO_W)'(ay_reg[MAG_W-1:LO_W])
                        * (HI_W+LO_W)'(ay_reg[LO_W-1:0]);
            hlz_reg  <= (HI_W+LO_W)'(az_reg[MAG_W-1:LO_W])
                        * (HI_W+LO_W)'(az_reg[LO_W-1:0]);
            hhx_reg  <= (2*HI_W)'(ax_reg[MAG_W-1:LO_W]) * (2*HI_W)'(ax_reg[MAG_W-1:LO_W]);
            hhy_reg  <= (2*HI_W)'(ay_reg[MAG_W-1:LO_W]) * (2*HI_W)'(ay_reg[MAG_W-1:LO_W]);
            hhz_reg  <= (2*HI_W)'(az_reg[MAG_W-1:LO_W]) * (2*HI_W)'(az_reg[MAG_W-1:LO_W]);
            on5_reg  <= on4_reg;
            vsq5_reg <= vsq4_reg;
        end
    end

    // stage 6: recombine each square
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg   <= (MSQ_W'(hhx_reg) << (2*LO_W)) + (MSQ_W'(hlx_reg) << (LO_W+1))
                        + MSQ_W'(llx_reg);
            qy_reg   <= (MSQ_W'(hhy_reg) << (2*LO_W)) + (MSQ_W'(hly_reg) << (LO_W+1))
                        + MSQ_W'(lly_reg);
            qz_reg   <= (MSQ_W'(hhz_reg) << (2*LO_W)) + (MSQ_W'(hlz_reg) << (LO_W+1))
                        + MSQ_W'(llz_reg);
            on6_reg  <= on5_reg;
            vsq6_reg <= vsq5_reg;
        end
    end

    // stage 7: squared length of the cross product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            msq_reg  <= qx_reg + qy_reg + qz_reg;
            on7_reg  <= on6_reg;
            vsq7_reg <= vsq6_reg;
        end
    end

    assign ctl.valid   = vld_reg[FRONT_STAGES];
    assign ctl.on_line = on7_reg;
    assign ctl.degen   = degen_reg[FRONT_STAGES];
    assign msq         = msq_reg;
    assign vsq         = vsq7_reg;

endmodule

// ----- sv/pld_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module pld_div
    import pld_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  pld_ctl_t         ctl_in,
    input  logic [MSQ_W-1:0] msq,
    input  logic [VSQ_W-1:0] vsq,
    output pld_ctl_t         ctl_out,
    output logic [QW-1:0]    quo
);

    // stage registers; x holds unused dividend bits on top, quotient bits below
    pld_ctl_t         c_reg   [1:QW];
    logic [VSQ_W-1:0] rem_reg [1:QW];
    logic [QW-1:0]    x_reg   [1:QW];
    logic [VSQ_W-1:0] w_reg   [1:QW-1];

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        pld_ctl_t         c_p;
        logic [VSQ_W-1:0] rem_p;
        logic [QW-1:0]    x_p;
        logic [VSQ_W-1:0] w_p;
        logic [VSQ_W+1:0] diff;
        logic [VSQ_W:0]   shifted;
        logic             ge;

        // previous stage or the pipeline input
        if (k == 0)
        begin : g_first
            // top dividend bits start below the divisor for any valid operand
            assign c_p   = ctl_in;
            assign rem_p = msq[MSQ_W-1:QW];
            assign x_p   = msq[QW-1:0];
            assign w_p   = vsq;
        end
        else
        begin : g_next
            assign c_p   = c_reg[k];
            assign rem_p = rem_reg[k];
            assign x_p   = x_reg[k];
            assign w_p   = w_reg[k];
        end

        // trial subtract
        assign shifted = {rem_p, x_p[QW-1]};
        assign diff    = {1'b0, shifted} - {2'b00, w_p};
        assign ge      = !diff[VSQ_W+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_reg[k+1] <= '0;
            end
            else if (en)
            begin
                c_reg[k+1] <= c_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? diff[VSQ_W-1:0] : shifted[VSQ_W-1:0];
                x_reg[k+1]   <= {x_p[QW-2:0], ge};
            end
        end

        // divisor only needed by later stages
        if (k < QW - 1)
        begin : g_w
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    w_reg[k+1] <= w_p;
                end
            end
        end
    end

    assign ctl_out = c_reg[QW];
    assign quo     = x_reg[QW];

endmodule

// ----- sv/pld_sqrt.sv -----
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module pld_sqrt
    import pld_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  pld_ctl_t          ctl_in,
    input  logic [QW-1:0]     rad,
    output pld_ctl_t          ctl_out,
    output logic [RT_W-1:0]   root
);

    // stage registers; x holds the radicand bits not yet brought down
    pld_ctl_t          c_reg    [1:RT_W];
    logic [SRM_W:0]    rem_reg  [1:RT_W];
    logic [RT_W-1:0]   root_reg [1:RT_W];
    logic [QW-1:0]     x_reg    [1:RT_W-1];

    for (genvar k = 0; k < RT_W; k++)
    begin : g_step
        pld_ctl_t        c_p;
        logic [SRM_W:0]  rem_p;
        logic [RT_W-1:0] root_p;
        logic [QW-1:0]   x_p;
        logic [SRM_W+2:0] shifted;
        logic [SRM_W+3:0] diff;
        logic [SRM_W:0]  trial;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign c_p    = ctl_in;
            assign rem_p  = '0;
            assign root_p = '0;
            assign x_p    = rad;
        end
        else
        begin : g_next
            assign c_p    = c_reg[k];
            assign rem_p  = rem_reg[k];
            assign root_p = root_reg[k];
            assign x_p    = x_reg[k];
        end

        // bring down two bits and try root*4 + 1
        assign shifted = {rem_p, x_p[QW-1:QW-2]};
        assign trial   = {root_p, 2'b01};
        assign diff    = {1'b0, shifted} - (SRM_W+4)'(trial);
        assign ge      = !diff[SRM_W+3];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_reg[k+1] <= '0;
            end
            else if (en)
            begin
                c_reg[k+1] <= c_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? diff[SRM_W:0] : shifted[SRM_W:0];
                root_reg[k+1] <= {root_p[RT_W-2:0], ge};
            end
        end

        // radicand only needed by later stages
        if (k < RT_W - 1)
        begin : g_x
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k+1] <= {x_p[QW-3:0], 2'b00};
                end
            end
        end
    end

    assign ctl_out = c_reg[RT_W];
    assign root    = root_reg[RT_W];

endmodule

// ----- sv/point_line_distance_3d.sv -----
// top level: distance from a 3d point to a line, fully pipelined
//
// req carries one query per beat: point, line base and line direction,
// all signed q16.16. rsp returns one beat per query, in order: on_line
// when the cross product (base - point) x dir is exactly zero, degenerate
// when dir is all zero, and distance as unsigned q18.16 rounded down
// (zero whenever either flag is set).
// from an accepted req beat to its rsp beat, a query passes the front stages
// of subtract, cross product and squaring, a restoring divider that settles
// one quotient bit per stage, and a square root that settles one root bit
// per stage.
// throughput is one beat per cycle while rsp does not stall; every stage carries its own valid bit.
// when rsp stalls with a beat waiting, the whole pipeline holds and req
// ready drops; bubbles inside the pipeline are not squeezed out.
// reset clears all valid bits; the data registers are not reset.
`timescale 1ns / 1ps

module point_line_distance_3d
    import pld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pld_in_if.sink     req,
    pld_out_if.source  rsp
);

    pld_ctl_t          front_ctl;
    pld_ctl_t          div_ctl;
    pld_ctl_t          sqrt_ctl;
    logic [MSQ_W-1:0]  msq;
    logic [VSQ_W-1:0]  vsq;
    logic [QW-1:0]     quo;
    logic [RT_W-1:0]   root;
    logic              en;

    // pipeline advances unless the last beat is stuck
    assign en        = !sqrt_ctl.valid || rsp.ready;
    assign req.ready = en;

    pld_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (req.valid),
        .point_x  (req.point_x),
        .point_y  (req.point_y),
        .point_z  (req.point_z),
        .base_x   (req.base_x),
        .base_y   (req.base_y),
        .base_z   (req.base_z),
        .dir_x    (req.dir_x),
        .dir_y    (req.dir_y),
        .dir_z    (req.dir_z),
        .ctl      (front_ctl),
        .msq      (msq),
        .vsq      (vsq)
    );

    pld_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (front_ctl),
        .msq     (msq),
        .vsq     (vsq),
        .ctl_out (div_ctl),
        .quo     (quo)
    );

    pld_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (div_ctl),
        .rad     (quo),
        .ctl_out (sqrt_ctl),
        .root    (root)
    );

    // output beat from the last stage
    assign rsp.valid      = sqrt_ctl.valid;
    assign rsp.on_line    = sqrt_ctl.on_line;
    assign rsp.degenerate = sqrt_ctl.degen;
    assign rsp.distance   = (sqrt_ctl.on_line || sqrt_ctl.degen)
                            ? '0 : DIST_W'(root);

endmodule
